>>> rtl/afsc_pkg.sv
// afsc_pkg: command, cull reason and register index codes for the box culler.
// Shared by aabb_frustum_screen_cull and its port checker; no dependencies.
package afsc_pkg;

  // Command codes on in_cmd; the fourth code is ignored
  localparam logic [1:0] CMD_TEST  = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Cull reasons on out_cull_reason
  localparam logic [1:0] REASON_NONE    = 2'd0;
  localparam logic [1:0] REASON_FRUSTUM = 2'd1;
  localparam logic [1:0] REASON_SMALL   = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_SHOW_ALL = 3'd0;
  localparam logic [2:0] CFG_TAN_FOV  = 3'd1;
  localparam logic [2:0] CFG_ORTHO    = 3'd2;
  localparam logic [2:0] CFG_VP_H     = 3'd3;
  localparam logic [2:0] CFG_MIN_PX   = 3'd4;
  localparam logic [2:0] CFG_CAM_X    = 3'd5;
  localparam logic [2:0] CFG_CAM_Y    = 3'd6;
  localparam logic [2:0] CFG_CAM_Z    = 3'd7;

endpackage

>>> rtl/aabb_frustum_screen_cull.sv
// aabb_frustum_screen_cull: box culling against stored planes plus a minimum screen size test.
// Plane store is a small synchronous memory; all products share one 34x34 multiplier.
// Depends on afsc_pkg.
//
//   channel | ports                       | direction | beat when
//   input   | in_valid / in_stall, in_*   | in        | in_valid && !in_stall
//   result  | out_valid / out_stall, out_*| out       | out_valid && !out_stall
//   config  | cfg_we, cfg_index, cfg_data | in        | cfg_we
//
// A test walks the plane slots in turn, skipping invalid ones and taking three products for
// each valid one, then sizes the box on the ortho, fill-screen, negative-side or perspective
// path. With show_all set a test skips to its result; a frustum cull ends at its plane.
// The work is serial: one shared multiplier and one plane memory read port.
// Synchronous active-low reset clears control state and plane valid marks; no clearing pass.
// A finished result waits in the output register; input is taken again once it is parked there.
module aabb_frustum_screen_cull import afsc_pkg::*; #(
  parameter int PLANE_SLOTS = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_box_min_x,
  input  logic signed [31:0] in_box_min_y,
  input  logic signed [31:0] in_box_min_z,
  input  logic signed [31:0] in_box_max_x,
  input  logic signed [31:0] in_box_max_y,
  input  logic signed [31:0] in_box_max_z,
  input  logic [2:0]         in_plane_slot,
  input  logic signed [15:0] in_normal_x,
  input  logic signed [15:0] in_normal_y,
  input  logic signed [15:0] in_normal_z,
  input  logic signed [31:0] in_plane_offset,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_visible,
  output logic [1:0]         out_cull_reason,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int SLOT_W = (PLANE_SLOTS > 1) ? $clog2(PLANE_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PLANE_SLOTS - 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_PL_NEXT, ST_PL_M0, ST_PL_M1, ST_PL_M2, ST_PL_CHK,
    ST_SZ_SIDE, ST_SZ_DH, ST_SZ_MODE, ST_SZ_ORTHO,
    ST_P_SQ0, ST_P_SQ1, ST_P_SQ2, ST_P_MT, ST_P_MTSQ, ST_P_MT2, ST_P_MT2L,
    ST_P_RHS, ST_P_LHS, ST_P_WAIT, ST_P_CMP, ST_OUT
  } state_t;

  // configuration
  logic        show_all_r;
  logic [15:0] tan_r;
  logic [30:0] ortho_r;
  logic [12:0] vp_h_r;
  logic [15:0] min_px_r;
  logic signed [31:0] cam_r [3];

  // plane store: {nx, ny, nz, offset}
  logic [79:0] plane_mem [PLANE_SLOTS];
  logic [79:0] rd_r;
  logic [PLANE_SLOTS-1:0] plane_valid_r;
  logic [3:0]  slot_ext;

  state_t state_r;
  logic [SLOT_W-1:0] s_r;
  logic signed [31:0] mn_r [3];
  logic signed [31:0] mx_r [3];
  logic [1:0]  reason_r;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] product_r;
  logic signed [51:0] acc_r, plane_sum;
  logic signed [32:0] side_r, dx, dy, dz, side_c;
  logic signed [45:0] dh_r;
  logic [31:0] dabs_r [3];
  logic [67:0] d2_r;
  logic [31:0] mt_r;
  logic [63:0] mt2_r;
  logic [95:0] d2_ext;
  logic [63:0] dh_ext;
  logic [2:0]  k_r;
  logic [1:0]  sh_r;
  logic        pp_v_r, pp_rhs_r;
  logic [135:0] pp_shift, rhs_r;
  logic [89:0]  lhs_r;
  logic signed [15:0] n_sel;
  logic signed [31:0] pv_sel;
  logic signed [31:0] off_rd;

  logic        out_valid_r, out_visible_r;
  logic [1:0]  out_reason_r;

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_visible     = out_visible_r;
  assign out_cull_reason = out_reason_r;
  assign slot_ext        = {1'b0, in_plane_slot};

  function automatic logic [31:0] axis_dist(input logic signed [31:0] c,
                                            input logic signed [31:0] lo,
                                            input logic signed [31:0] hi);
    logic signed [31:0] cl;
    logic signed [32:0] d;
    if (c < lo)      cl = lo;
    else if (c < hi) cl = c;
    else             cl = hi;
    d = {c[31], c} - {cl[31], cl};
    axis_dist = d[32] ? 32'(-d) : d[31:0];
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      show_all_r <= 1'b0;
      tan_r      <= '0;
      ortho_r    <= '0;
      vp_h_r     <= '0;
      min_px_r   <= '0;
      cam_r[0]   <= '0;
      cam_r[1]   <= '0;
      cam_r[2]   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SHOW_ALL: show_all_r <= cfg_data[0];
        CFG_TAN_FOV:  tan_r      <= cfg_data[15:0];
        CFG_ORTHO:    ortho_r    <= cfg_data[30:0];
        CFG_VP_H:     vp_h_r     <= cfg_data[12:0];
        CFG_MIN_PX:   min_px_r   <= cfg_data[15:0];
        CFG_CAM_X:    cam_r[0]   <= cfg_data;
        CFG_CAM_Y:    cam_r[1]   <= cfg_data;
        CFG_CAM_Z:    cam_r[2]   <= cfg_data;
        default:      ;
      endcase
    end
  end

  // plane memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall && in_cmd == CMD_LOAD && in_plane_slot < PLANE_SLOTS) begin
      plane_mem[slot_ext[SLOT_W-1:0]] <= {in_normal_x, in_normal_y, in_normal_z,
                                          in_plane_offset};
    end
    rd_r <= plane_mem[s_r];
  end

  assign off_rd   = rd_r[31:0];
  assign d2_ext   = {28'b0, d2_r};
  assign dh_ext   = {19'b0, dh_r[44:0]};
  assign pp_shift = 136'(product_r[63:0]) << {sh_r, 5'b0};
  assign plane_sum = acc_r + product_r[51:0];

  always_comb begin
    dx = {mx_r[0][31], mx_r[0]} - {mn_r[0][31], mn_r[0]};
    dy = {mx_r[1][31], mx_r[1]} - {mn_r[1][31], mn_r[1]};
    dz = {mx_r[2][31], mx_r[2]} - {mn_r[2][31], mn_r[2]};
    side_c = dx;
    if (dy > side_c) side_c = dy;
    if (dz > side_c) side_c = dz;
  end

  // p-vertex axis for the current plane step
  always_comb begin
    case (state_r)
      ST_PL_M1: n_sel = rd_r[63:48];
      ST_PL_M2: n_sel = rd_r[47:32];
      default:  n_sel = rd_r[79:64];
    endcase
    case (state_r)
      ST_PL_M1: pv_sel = n_sel[15] ? mn_r[1] : mx_r[1];
      ST_PL_M2: pv_sel = n_sel[15] ? mn_r[2] : mx_r[2];
      default:  pv_sel = n_sel[15] ? mn_r[0] : mx_r[0];
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_PL_M0, ST_PL_M1, ST_PL_M2: begin
        mul_a = {{18{n_sel[15]}}, n_sel};
        mul_b = {{2{pv_sel[31]}}, pv_sel};
      end
      ST_SZ_DH: begin
        mul_a = {side_r[32], side_r};
        mul_b = {21'b0, vp_h_r};
      end
      ST_SZ_MODE: begin
        mul_a = {18'b0, min_px_r};
        mul_b = {3'b0, ortho_r};
      end
      ST_P_SQ0: begin
        mul_a = {2'b0, dabs_r[0]};
        mul_b = {2'b0, dabs_r[0]};
      end
      ST_P_SQ1: begin
        mul_a = {2'b0, dabs_r[1]};
        mul_b = {2'b0, dabs_r[1]};
      end
      ST_P_SQ2: begin
        mul_a = {2'b0, dabs_r[2]};
        mul_b = {2'b0, dabs_r[2]};
      end
      ST_P_MT: begin
        mul_a = {18'b0, min_px_r};
        mul_b = {18'b0, tan_r};
      end
      ST_P_MT2: begin
        mul_a = {2'b0, mt_r};
        mul_b = {2'b0, mt_r};
      end
      ST_P_RHS: begin
        mul_a = {2'b0, mt2_r[{k_r[0], 5'b0} +: 32]};
        mul_b = {2'b0, d2_ext[{k_r[2:1], 5'b0} +: 32]};
      end
      ST_P_LHS: begin
        mul_a = {2'b0, dh_ext[{k_r[0], 5'b0} +: 32]};
        mul_b = {2'b0, dh_ext[{k_r[1], 5'b0} +: 32]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    product_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      plane_valid_r <= '0;
      out_valid_r   <= 1'b0;
      pp_v_r        <= 1'b0;
    end else begin
      // a partial product issued this cycle lands in product_r next cycle
      pp_v_r <= (state_r == ST_P_RHS) || (state_r == ST_P_LHS);
      if (pp_v_r) begin
        if (pp_rhs_r) rhs_r <= rhs_r + pp_shift;
        else          lhs_r <= lhs_r + pp_shift[89:0];
      end
      if (out_valid_r && !out_stall && state_r != ST_OUT) out_valid_r <= 1'b0;

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            case (in_cmd)
              CMD_LOAD: begin
                if (in_plane_slot < PLANE_SLOTS) plane_valid_r[slot_ext[SLOT_W-1:0]] <= 1'b1;
              end
              CMD_CLEAR: plane_valid_r <= '0;
              CMD_TEST: begin
                mn_r[0] <= in_box_min_x;
                mn_r[1] <= in_box_min_y;
                mn_r[2] <= in_box_min_z;
                mx_r[0] <= in_box_max_x;
                mx_r[1] <= in_box_max_y;
                mx_r[2] <= in_box_max_z;
                s_r     <= '0;
                if (show_all_r) begin
                  reason_r <= REASON_NONE;
                  state_r  <= ST_OUT;
                end else begin
                  state_r  <= ST_PL_NEXT;
                end
              end
              default: ;
            endcase
          end
        end
        ST_PL_NEXT: begin
          // rd_r picks up plane_mem[s_r] at this edge
          if (plane_valid_r[s_r])   state_r <= ST_PL_M0;
          else if (s_r == LAST_SLOT) state_r <= ST_SZ_SIDE;
          else                      s_r     <= s_r + 1'b1;
        end
        ST_PL_M0: begin
          acc_r   <= -{{6{off_rd[31]}}, off_rd, 14'b0};
          state_r <= ST_PL_M1;
        end
        ST_PL_M1: begin
          acc_r   <= acc_r + product_r[51:0];
          state_r <= ST_PL_M2;
        end
        ST_PL_M2: begin
          acc_r   <= acc_r + product_r[51:0];
          state_r <= ST_PL_CHK;
        end
        ST_PL_CHK: begin
          if (plane_sum[51]) begin
            reason_r <= REASON_FRUSTUM;
            state_r  <= ST_OUT;
          end else if (s_r == LAST_SLOT) begin
            state_r  <= ST_SZ_SIDE;
          end else begin
            s_r      <= s_r + 1'b1;
            state_r  <= ST_PL_NEXT;
          end
        end
        ST_SZ_SIDE: begin
          side_r    <= side_c;
          dabs_r[0] <= axis_dist(cam_r[0], mn_r[0], mx_r[0]);
          dabs_r[1] <= axis_dist(cam_r[1], mn_r[1], mx_r[1]);
          dabs_r[2] <= axis_dist(cam_r[2], mn_r[2], mx_r[2]);
          state_r   <= ST_SZ_DH;
        end
        ST_SZ_DH: state_r <= ST_SZ_MODE;
        ST_SZ_MODE: begin
          dh_r <= product_r[45:0];
          if (ortho_r != '0) begin
            state_r <= ST_SZ_ORTHO;
          end else if (tan_r == '0) begin
            // fills the screen
            reason_r <= ({vp_h_r, 8'b0} < {5'b0, min_px_r}) ? REASON_SMALL : REASON_NONE;
            state_r  <= ST_OUT;
          end else if (product_r[45]) begin
            reason_r <= REASON_SMALL;
            state_r  <= ST_OUT;
          end else begin
            state_r  <= ST_P_SQ0;
          end
        end
        ST_SZ_ORTHO: begin
          reason_r <= ($signed({{2{dh_r[45]}}, dh_r, 8'b0}) < $signed({9'b0, product_r[46:0]}))
                      ? REASON_SMALL : REASON_NONE;
          state_r  <= ST_OUT;
        end
        ST_P_SQ0: begin
          d2_r    <= '0;
          rhs_r   <= '0;
          lhs_r   <= '0;
          state_r <= ST_P_SQ1;
        end
        ST_P_SQ1: begin
          d2_r    <= d2_r + product_r[67:0];
          state_r <= ST_P_SQ2;
        end
        ST_P_SQ2: begin
          d2_r    <= d2_r + product_r[67:0];
          state_r <= ST_P_MT;
        end
        ST_P_MT: begin
          d2_r    <= d2_r + product_r[67:0];
          state_r <= ST_P_MTSQ;
        end
        ST_P_MTSQ: begin
          mt_r <= product_r[31:0];
          // distance floored at 1.0
          if (d2_r < 68'd65536) d2_r <= 68'd65536;
          state_r <= ST_P_MT2;
        end
        ST_P_MT2: state_r <= ST_P_MT2L;
        ST_P_MT2L: begin
          mt2_r   <= product_r[63:0];
          k_r     <= '0;
          state_r <= ST_P_RHS;
        end
        ST_P_RHS: begin
          pp_rhs_r <= 1'b1;
          sh_r     <= 2'(k_r[0]) + k_r[2:1];
          if (k_r == 3'd5) begin
            k_r     <= '0;
            state_r <= ST_P_LHS;
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        ST_P_LHS: begin
          pp_rhs_r <= 1'b0;
          sh_r     <= 2'(k_r[0]) + 2'(k_r[1]);
          if (k_r == 3'd3) state_r <= ST_P_WAIT;
          else             k_r     <= k_r + 1'b1;
        end
        ST_P_WAIT: state_r <= ST_P_CMP;
        ST_P_CMP: begin
          // (side*H)^2 * 2^40 against (M*T)^2 * d2
          reason_r <= ({6'b0, lhs_r, 40'b0} < rhs_r) ? REASON_SMALL : REASON_NONE;
          state_r  <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r   <= 1'b1;
            out_visible_r <= (reason_r == REASON_NONE);
            out_reason_r  <= reason_r;
            state_r       <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/afsc_checker.sv
// afsc_checker: port-level checks on aabb_frustum_screen_cull, bound to the top level.
// Depends on afsc_pkg.
module afsc_checker import afsc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_cmd,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_visible,
  input logic [1:0] out_cull_reason
);

  // held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_visible) && $stable(out_cull_reason))
    else $error("result beat changed while stalled");

  a_vis_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_visible == (out_cull_reason == REASON_NONE)))
    else $error("visible flag disagrees with cull reason");

  a_reason_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cull_reason == REASON_NONE || out_cull_reason == REASON_FRUSTUM ||
                   out_cull_reason == REASON_SMALL))
    else $error("unused cull reason code");

  // plane load, clear and the unused code never raise a result
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_cmd != CMD_TEST |=> !$rose(out_valid))
    else $error("result raised by a non-test command");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind aabb_frustum_screen_cull afsc_checker u_afsc_checker (.*);
